// ===== hdl/sfr_pkg.sv =====
package sfr_pkg;

    // register indexes on the configuration port
    localparam logic [7:0] CFG_START_FIRST  = 8'd0;
    localparam logic [7:0] CFG_START_SECOND = 8'd1;
    localparam logic [7:0] CFG_MAX_PAYLOAD  = 8'd2;
    localparam logic [7:0] CFG_GAP_LIMIT    = 8'd3;

    // reset values of the registers
    localparam logic [7:0]  RST_START_FIRST  = 8'd0;
    localparam logic [7:0]  RST_START_SECOND = 8'd0;
    localparam logic [5:0]  RST_MAX_PAYLOAD  = 6'd25;
    localparam logic [15:0] RST_GAP_LIMIT    = 16'd100;

    localparam logic [15:0] GAP_SAT = 16'hFFFF;

    // frame status codes
    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_LEN = 2'd1;
    localparam logic [1:0] ST_CHK = 2'd2;

    typedef struct packed {
        logic [7:0]  start_first;
        logic [7:0]  start_second;
        logic [5:0]  max_payload;
        logic [15:0] gap_limit;
    } t_cfg;

    typedef struct packed {
        logic [7:0] frame_cmd;
        logic [1:0] frame_status;
        logic [7:0] payload_byte;
        logic       payload_valid;
        logic [7:0] payload_len;
        logic       last;
    } t_result;

endpackage

// ===== hdl/sfr_mem.sv =====
module sfr_mem #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/sfr_ctrl.sv =====
module sfr_ctrl #(
    parameter int DEPTH = 32,
    parameter int AW    = 5,
    parameter int CW    = 6
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sfr_pkg::t_cfg    i_cfg,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_func,
    input  logic [7:0]       i_byte,
    input  logic             i_out_free,
    output logic             o_res_valid,
    output sfr_pkg::t_result o_res,
    output logic             o_mem_we,
    output logic [AW-1:0]    o_mem_waddr,
    output logic [7:0]       o_mem_wdata,
    output logic             o_mem_re,
    output logic [AW-1:0]    o_mem_raddr,
    input  logic [7:0]       i_mem_rdata
);
    import sfr_pkg::*;

    localparam logic [2:0] PH_HUNT0 = 3'd0;
    localparam logic [2:0] PH_HUNT1 = 3'd1;
    localparam logic [2:0] PH_CMD   = 3'd2;
    localparam logic [2:0] PH_LEN   = 3'd3;
    localparam logic [2:0] PH_DATA  = 3'd4;
    localparam logic [2:0] PH_CHK   = 3'd5;

    localparam logic [8:0] DEPTH9 = 9'(DEPTH);

    logic [2:0]    r_phase, n_phase;
    logic [7:0]    r_xor, n_xor;
    logic [7:0]    r_cmd, n_cmd;
    logic [7:0]    r_len, n_len;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [15:0]   r_gap, n_gap;
    logic          r_drain, n_drain;
    logic          r_pend, n_pend;
    logic [CW-1:0] r_idx, n_idx;

    logic       ready;
    logic       byte_acc;
    logic       tick_acc;
    logic [2:0] phase_eff;
    logic [8:0] limit;
    logic       rd_last;

    assign ready    = !r_drain && i_out_free;
    assign byte_acc = i_in_valid && ready && !i_func;
    assign tick_acc = i_in_valid && ready && i_func;

    assign phase_eff = (r_gap > i_cfg.gap_limit) ? PH_HUNT0 : r_phase;
    assign limit     = ({3'b0, i_cfg.max_payload} > DEPTH9) ? DEPTH9
                                                             : {3'b0, i_cfg.max_payload};
    assign rd_last   = (9'(r_idx) + 9'd1) == {1'b0, r_len};

    always_comb begin
        n_phase = r_phase;
        n_xor   = r_xor;
        n_cmd   = r_cmd;
        n_len   = r_len;
        n_cnt   = r_cnt;
        n_gap   = r_gap;
        n_drain = r_drain;
        n_pend  = 1'b0;
        n_idx   = r_idx;

        o_res_valid = 1'b0;
        o_res       = '{frame_cmd: r_cmd, frame_status: ST_OK, payload_byte: 8'd0,
                        payload_valid: 1'b0, payload_len: r_len, last: 1'b1};
        o_mem_we    = 1'b0;
        o_mem_waddr = r_cnt[AW-1:0];
        o_mem_wdata = i_byte;
        o_mem_re    = 1'b0;
        o_mem_raddr = r_idx[AW-1:0];

        if (tick_acc) begin
            if (r_gap != GAP_SAT) begin
                n_gap = r_gap + 16'd1;
            end
        end

        if (byte_acc) begin
            n_gap = 16'd0;
            case (phase_eff)
                PH_HUNT1: begin
                    if (i_byte == i_cfg.start_second) begin
                        n_xor   = r_xor ^ i_byte;
                        n_phase = PH_CMD;
                    end else begin
                        n_phase = PH_HUNT0;
                    end
                end
                PH_CMD: begin
                    n_cmd   = i_byte;
                    n_xor   = r_xor ^ i_byte;
                    n_phase = PH_LEN;
                end
                PH_LEN: begin
                    n_len = i_byte;
                    n_xor = r_xor ^ i_byte;
                    if (i_byte == 8'd0) begin
                        n_phase = PH_CHK;
                    end else if ({1'b0, i_byte} > limit) begin
                        n_phase                 = PH_HUNT0;
                        o_res_valid             = 1'b1;
                        o_res.frame_status      = ST_LEN;
                        o_res.payload_len       = i_byte;
                    end else begin
                        n_phase = PH_DATA;
                    end
                end
                PH_DATA: begin
                    o_mem_we = 9'(r_cnt) < DEPTH9;
                    n_cnt    = r_cnt + 1'b1;
                    n_xor    = r_xor ^ i_byte;
                    if ((9'(r_cnt) + 9'd1) >= {1'b0, r_len}) begin
                        n_phase = PH_CHK;
                    end
                end
                PH_CHK: begin
                    n_phase = PH_HUNT0;
                    if (r_xor != i_byte) begin
                        o_res_valid        = 1'b1;
                        o_res.frame_status = ST_CHK;
                    end else if (r_len == 8'd0) begin
                        o_res_valid = 1'b1;
                    end else begin
                        // good frame with payload: stream it out of the store
                        n_drain = 1'b1;
                        n_idx   = '0;
                    end
                end
                default: begin
                    if (i_byte == i_cfg.start_first) begin
                        n_phase = PH_HUNT1;
                        n_xor   = i_byte;
                        n_cnt   = '0;
                    end else begin
                        n_phase = PH_HUNT0;
                    end
                end
            endcase
        end

        // drain: read one entry, then load it into the output register the cycle after.
        // input is held off while draining, so store writes and reads never overlap
        if (r_pend) begin
            o_res_valid         = 1'b1;
            o_res.payload_byte  = i_mem_rdata;
            o_res.payload_valid = 1'b1;
            o_res.last          = rd_last;
            n_idx               = r_idx + 1'b1;
            if (rd_last) begin
                n_drain = 1'b0;
            end
        end else if (r_drain && i_out_free) begin
            o_mem_re = 1'b1;
            n_pend   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT0;
            r_xor   <= 8'd0;
            r_cmd   <= 8'd0;
            r_len   <= 8'd0;
            r_cnt   <= '0;
            r_gap   <= 16'd0;
            r_drain <= 1'b0;
            r_pend  <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_phase <= n_phase;
            r_xor   <= n_xor;
            r_cmd   <= n_cmd;
            r_len   <= n_len;
            r_cnt   <= n_cnt;
            r_gap   <= n_gap;
            r_drain <= n_drain;
            r_pend  <= n_pend;
            r_idx   <= n_idx;
        end
    end

    assign o_in_ready = ready;

endmodule

// ===== hdl/serial_frame_receiver.sv =====
// Serial frame receiver. Takes received bytes (tuser 0) and time ticks (tuser 1)
// and parses frames of two start bytes, command, length, payload and an XOR
// checksum byte. A length above max_payload or above PAYLOAD_DEPTH gives one
// length error result at once; at the checksum byte a bad frame gives one
// checksum error result, an empty good frame one ok result, and a good frame
// with payload one result per payload byte with tlast on the final one. More
// than gap_limit ticks between bytes sends the parser back to hunting. Input
// is taken at one item per cycle while the output register is free or being
// emptied and no payload is being released. Payload bytes sit in a small
// synchronous memory; each payload byte is released by one memory read and
// then one output register load. The memory needs no clearing after reset.
module serial_frame_receiver #(
    parameter int PAYLOAD_DEPTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    // input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    input  logic        i_s_tuser,   // [0] func
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [7:0] frame_cmd, [9:8] frame_status,
                                     // [17:10] payload_byte, [25:18] payload_len
    output logic        o_m_tuser,   // [0] payload_valid
    output logic        o_m_tlast
);
    import sfr_pkg::*;

    localparam int AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
    localparam int CW = $clog2(PAYLOAD_DEPTH + 1);

    t_cfg          r_cfg;
    logic          r_ovalid;
    t_result       r_ores;
    logic          out_free;
    logic          res_valid;
    t_result       res;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [7:0]    mem_rdata;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_first  <= RST_START_FIRST;
            r_cfg.start_second <= RST_START_SECOND;
            r_cfg.max_payload  <= RST_MAX_PAYLOAD;
            r_cfg.gap_limit    <= RST_GAP_LIMIT;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_START_FIRST:  r_cfg.start_first  <= i_cfg_data[7:0];
                CFG_START_SECOND: r_cfg.start_second <= i_cfg_data[7:0];
                CFG_MAX_PAYLOAD:  r_cfg.max_payload  <= i_cfg_data[5:0];
                CFG_GAP_LIMIT:    r_cfg.gap_limit    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign out_free = !r_ovalid || i_m_tready;

    sfr_ctrl #(
        .DEPTH (PAYLOAD_DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_s_tvalid),
        .o_in_ready  (o_s_tready),
        .i_func      (i_s_tuser),
        .i_byte      (i_s_tdata),
        .i_out_free  (out_free),
        .o_res_valid (res_valid),
        .o_res       (res),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    sfr_mem #(
        .DEPTH (PAYLOAD_DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // output register, loaded only when free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (res_valid) begin
            r_ovalid <= 1'b1;
        end else if (i_m_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_ores <= res;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {6'd0, r_ores.payload_len, r_ores.payload_byte,
                         r_ores.frame_status, r_ores.frame_cmd};
    assign o_m_tuser  = r_ores.payload_valid;
    assign o_m_tlast  = r_ores.last;

endmodule
